// ===== rtl/jepd_pkg.sv =====
// Shared types and constants for the J1939 engine parameter decoder.
// Used by the front, queue, back and top-level modules; no dependencies.
`timescale 1ns / 1ps

package jepd_pkg;

    localparam int ID_W      = 29;
    localparam int LEN_W     = 4;
    localparam int SPEED_W   = 19;
    localparam int COOLANT_W = 9;
    localparam int BATTERY_W = 16;
    localparam int FUEL_W    = 8;
    localparam int COUNT_W   = 32;
    localparam int IN_DATA_W  = 104;
    localparam int OUT_DATA_W = 88;

    localparam logic [7:0]  PF_PDU2      = 8'hF0;
    localparam logic [15:0] PGN_EEC1     = 16'hF004;
    localparam logic [15:0] PGN_PROP_SPD = 16'hFF66;
    localparam logic [15:0] PGN_COOLANT  = 16'hFEEE;
    localparam logic [15:0] PGN_BATTERY  = 16'hFEF7;
    localparam logic [15:0] PGN_FUEL     = 16'hFEFC;
    localparam logic [15:0] NA_WORD      = 16'hFFFF;
    localparam logic [7:0]  NA_BYTE      = 8'hFF;
    localparam logic [7:0]  COOLANT_OFFSET = 8'd40;

    typedef enum logic [2:0] {
        KIND_NONE     = 3'd0,
        KIND_EEC1     = 3'd1,
        KIND_PROP_SPD = 3'd2,
        KIND_COOLANT  = 3'd3,
        KIND_BATTERY  = 3'd4,
        KIND_FUEL     = 3'd5
    } t_kind;

    typedef struct packed {
        t_kind                 kind;
        logic                  upd_speed;
        logic                  upd_coolant;
        logic                  upd_battery;
        logic                  upd_fuel;
        logic [SPEED_W-1:0]    speed;
        logic [COOLANT_W-1:0]  coolant;
        logic [BATTERY_W-1:0]  battery;
        logic [FUEL_W-1:0]     fuel;
    } t_op;

endpackage

// ===== rtl/jepd_front.sv =====
// Front end: unpacks a received frame, forms the PGN and classifies it into an update operation.
// Depends on jepd_pkg.
`timescale 1ns / 1ps

module jepd_front (
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [jepd_pkg::IN_DATA_W-1:0]    i_data,
    input  logic                              i_is_extended,
    output logic                              o_op_valid,
    input  logic                              i_op_ready,
    output jepd_pkg::t_op                     o_op
);

    logic [jepd_pkg::ID_W-1:0]  w_id;
    logic [jepd_pkg::LEN_W-1:0] w_len;
    logic [7:0]                 w_b [8];
    logic [7:0]                 w_pf;
    logic [15:0]                w_pgn;
    logic [15:0]                w_raw01;
    logic [15:0]                w_raw34;
    logic [15:0]                w_raw45;

    assign w_id  = i_data[28:0];
    assign w_len = i_data[32:29];

    always_comb begin
        for (int k = 0; k < 8; k++) begin
            w_b[k] = i_data[33 + 8*k +: 8];
        end
    end

    assign w_pf    = w_id[23:16];
    assign w_pgn   = {w_pf, (w_pf >= jepd_pkg::PF_PDU2) ? w_id[15:8] : 8'h00};
    assign w_raw01 = {w_b[1], w_b[0]};
    assign w_raw34 = {w_b[4], w_b[3]};
    assign w_raw45 = {w_b[5], w_b[4]};

    always_comb begin
        o_op             = '0;
        o_op.kind        = jepd_pkg::KIND_NONE;
        o_op.coolant     = {1'b0, w_b[0] - jepd_pkg::COOLANT_OFFSET}
                           - ((w_b[0] < jepd_pkg::COOLANT_OFFSET) ? 9'h100 : 9'h000);
        o_op.battery     = w_raw45;
        o_op.fuel        = w_b[1];
        o_op.speed       = {3'b000, w_raw34};
        if (i_is_extended) begin
            case (w_pgn)
                jepd_pkg::PGN_EEC1: begin
                    o_op.kind      = jepd_pkg::KIND_EEC1;
                    o_op.upd_speed = (w_len >= 4'd5) && (w_raw34 != jepd_pkg::NA_WORD);
                end
                jepd_pkg::PGN_PROP_SPD: begin
                    o_op.kind      = jepd_pkg::KIND_PROP_SPD;
                    o_op.speed     = {w_raw01, 3'b000};
                    o_op.upd_speed = (w_len >= 4'd2) && (w_raw01 != jepd_pkg::NA_WORD);
                end
                jepd_pkg::PGN_COOLANT: begin
                    o_op.kind        = jepd_pkg::KIND_COOLANT;
                    o_op.upd_coolant = (w_len >= 4'd1) && (w_b[0] != jepd_pkg::NA_BYTE);
                end
                jepd_pkg::PGN_BATTERY: begin
                    o_op.kind        = jepd_pkg::KIND_BATTERY;
                    o_op.upd_battery = (w_len >= 4'd6) && (w_raw45 != jepd_pkg::NA_WORD);
                end
                jepd_pkg::PGN_FUEL: begin
                    o_op.kind     = jepd_pkg::KIND_FUEL;
                    o_op.upd_fuel = (w_len >= 4'd2) && (w_b[1] != jepd_pkg::NA_BYTE);
                end
                default: begin
                    o_op.kind = jepd_pkg::KIND_NONE;
                end
            endcase
        end
    end

    assign o_op_valid = i_valid;
    assign o_ready    = i_op_ready;

endmodule

// ===== rtl/jepd_queue.sv =====
// Two-entry queue of classified operations between the front and back ends.
// Depends on jepd_pkg.
`timescale 1ns / 1ps

module jepd_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push_valid,
    output logic          o_push_ready,
    input  jepd_pkg::t_op i_push_op,
    output logic          o_pop_valid,
    input  logic          i_pop_ready,
    output jepd_pkg::t_op o_pop_op
);

    jepd_pkg::t_op r_mem [2];
    logic          r_wr_ptr;
    logic          r_rd_ptr;
    logic [1:0]    r_count;
    logic          w_push;
    logic          w_pop;

    assign o_push_ready = (r_count != 2'd2);
    assign o_pop_valid  = (r_count != 2'd0);
    assign o_pop_op     = r_mem[r_rd_ptr];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_op;
        end
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== rtl/jepd_back.sv =====
// Back end: applies operations to the held values and frame counter and registers the result.
// Depends on jepd_pkg.
`timescale 1ns / 1ps

module jepd_back (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_op_valid,
    output logic                               o_op_ready,
    input  jepd_pkg::t_op                      i_op,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [jepd_pkg::OUT_DATA_W-1:0]    o_data,
    output logic [2:0]                         o_kind
);

    logic [jepd_pkg::SPEED_W-1:0]   r_speed,   n_speed;
    logic [jepd_pkg::COOLANT_W-1:0] r_coolant, n_coolant;
    logic [jepd_pkg::BATTERY_W-1:0] r_battery, n_battery;
    logic [jepd_pkg::FUEL_W-1:0]    r_fuel,    n_fuel;
    logic [3:0]                     r_flags,   n_flags;
    logic [jepd_pkg::COUNT_W-1:0]   r_count,   n_count;
    logic                           r_out_valid;
    logic [jepd_pkg::OUT_DATA_W-1:0] r_out_data;
    logic [2:0]                     r_out_kind;
    logic                           w_take;

    assign o_op_ready = !r_out_valid || i_ready;
    assign w_take     = i_op_valid && o_op_ready;

    always_comb begin
        n_speed   = i_op.upd_speed   ? i_op.speed   : r_speed;
        n_coolant = i_op.upd_coolant ? i_op.coolant : r_coolant;
        n_battery = i_op.upd_battery ? i_op.battery : r_battery;
        n_fuel    = i_op.upd_fuel    ? i_op.fuel    : r_fuel;
        n_flags   = r_flags | {i_op.upd_fuel, i_op.upd_battery,
                               i_op.upd_coolant, i_op.upd_speed};
        n_count   = r_count + 32'd1;
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_out_data <= {n_count, n_flags[3], n_fuel, n_flags[2], n_battery,
                           n_flags[1], n_coolant, n_flags[0], n_speed};
            r_out_kind <= i_op.kind;
        end
        if (!i_rst_n) begin
            r_speed     <= '0;
            r_coolant   <= '0;
            r_battery   <= '0;
            r_fuel      <= '0;
            r_flags     <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_take) begin
                r_speed   <= n_speed;
                r_coolant <= n_coolant;
                r_battery <= n_battery;
                r_fuel    <= n_fuel;
                r_flags   <= n_flags;
                r_count   <= n_count;
            end
            if (w_take) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;
    assign o_kind  = r_out_kind;

endmodule

// ===== rtl/j1939_engine_parameter_decoder_unit.sv =====
// Top level of the J1939 engine parameter decoder.
// Depends on jepd_pkg, jepd_front, jepd_queue and jepd_back.
//
// Usage: each received CAN frame enters as one transaction on the slave
// stream. The front end forms the parameter group number and classifies the
// frame; a two-entry queue hands the operation to the back end, which updates
// the held engine values, counts the frame and registers one result
// transaction on the master stream.
// A frame accepted at one edge is classified into the queue at that edge;
// the back end takes it from the queue and registers its result. One frame
// is taken every cycle for as long as the receiver keeps taking results,
// the rate being set by the update of the held values in the back end.
// When the receiver stalls, the output register holds its result, the queue
// fills with up to two further frames, and then tready falls on the slave side.
// Reset clears the held values, their valid bits, the frame counter, the
// queue and the output valid bit; the block takes frames as soon as reset
// is released.
`timescale 1ns / 1ps

module j1939_engine_parameter_decoder_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // can_id[28:0], data_len[32:29], byte0..byte7 from bit 33 up, zeros to 104
    input  logic [jepd_pkg::IN_DATA_W-1:0]     i_s_axis_tdata,
    // is_extended
    input  logic                               i_s_axis_tuser,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // speed_eighths[18:0], speed_valid[19], coolant_deg[28:20], coolant_valid[29],
    // battery_units[45:30], battery_valid[46], fuel_units[54:47], fuel_valid[55],
    // frames_seen[87:56]
    output logic [jepd_pkg::OUT_DATA_W-1:0]    o_m_axis_tdata,
    // matched_kind
    output logic [2:0]                         o_m_axis_tuser
);

    logic          w_fq_valid;
    logic          w_fq_ready;
    jepd_pkg::t_op w_fq_op;
    logic          w_qb_valid;
    logic          w_qb_ready;
    jepd_pkg::t_op w_qb_op;

    jepd_front u_front (
        .i_valid       (i_s_axis_tvalid),
        .o_ready       (o_s_axis_tready),
        .i_data        (i_s_axis_tdata),
        .i_is_extended (i_s_axis_tuser),
        .o_op_valid    (w_fq_valid),
        .i_op_ready    (w_fq_ready),
        .o_op          (w_fq_op)
    );

    jepd_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_fq_valid),
        .o_push_ready (w_fq_ready),
        .i_push_op    (w_fq_op),
        .o_pop_valid  (w_qb_valid),
        .i_pop_ready  (w_qb_ready),
        .o_pop_op     (w_qb_op)
    );

    jepd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op_valid (w_qb_valid),
        .o_op_ready (w_qb_ready),
        .i_op       (w_qb_op),
        .o_valid    (o_m_axis_tvalid),
        .i_ready    (i_m_axis_tready),
        .o_data     (o_m_axis_tdata),
        .o_kind     (o_m_axis_tuser)
    );

endmodule
